// ===== hw/rtl/afx_pkg.sv =====
// ----------------------------------------------------------------------------
// afx_pkg
// Shared types, constants and fixed-point helpers for the 2D reflect and
// shear transform unit.
// ----------------------------------------------------------------------------
package afx_pkg;

   localparam int DATA_W        = 32;
   localparam int PROD_W        = 2 * DATA_W;
   localparam int WIDE_W        = PROD_W + 1;
   localparam int REQ_TYPE_W    = 3;
   localparam int FRAC_BITS_DEF = 16;

   typedef logic signed [DATA_W-1:0] elem_type;
   typedef logic signed [PROD_W-1:0] prod_type;
   typedef logic signed [WIDE_W-1:0] wide_type;

   // Matrix elements in row order: a00, a01, a10, a11.
   typedef elem_type mat_type [4];

   localparam elem_type ELEM_MAX = {1'b0, {(DATA_W-1){1'b1}}};
   localparam elem_type ELEM_MIN = {1'b1, {(DATA_W-1){1'b0}}};
   localparam wide_type WIDE_MAX = WIDE_W'(ELEM_MAX);
   localparam wide_type WIDE_MIN = WIDE_W'(ELEM_MIN);

   typedef enum logic [REQ_TYPE_W-1:0] {
      REQ_IDENTITY    = 3'd0,
      REQ_REFLECT_X   = 3'd1,
      REQ_REFLECT_Y   = 3'd2,
      REQ_REFLECT_ORG = 3'd3,
      REQ_REFLECT_XY  = 3'd4,
      REQ_SHEAR_X     = 3'd5,
      REQ_SHEAR_Y     = 3'd6,
      REQ_VERTEX      = 3'd7
   } req_code_type;

   typedef struct packed {
      logic [REQ_TYPE_W-1:0] req_type;
      elem_type              shear_factor;
      elem_type              vertex_x;
      elem_type              vertex_y;
      logic                  vertex_last;
   } req_item_type;

   typedef struct packed {
      elem_type out_x;
      elem_type out_y;
      logic     out_last;
   } rsp_item_type;

   // Fixed-point one for a given number of fraction bits.
   function automatic elem_type unit_value(input int frac_bits);
      return elem_type'(DATA_W'(1) << frac_bits);
   endfunction

   // Clamp a wide signed value into the element range.
   function automatic elem_type sat_elem(input wide_type v);
      elem_type r;
      if (v > WIDE_MAX) begin
         r = ELEM_MAX;
      end else if (v < WIDE_MIN) begin
         r = ELEM_MIN;
      end else begin
         r = v[DATA_W-1:0];
      end
      return r;
   endfunction

   // Negation; the most negative value maps to the most positive one.
   function automatic elem_type neg_sat(input elem_type v);
      elem_type r;
      if (v == ELEM_MIN) begin
         r = ELEM_MAX;
      end else begin
         r = -v;
      end
      return r;
   endfunction

endpackage

// ===== hw/rtl/afx_req_if.sv =====
// ----------------------------------------------------------------------------
// afx_req_if
// Request channel: valid/ready handshake with the request payload.
// ----------------------------------------------------------------------------
interface afx_req_if;
   import afx_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [REQ_TYPE_W-1:0] req_type;
   elem_type              shear_factor;
   elem_type              vertex_x;
   elem_type              vertex_y;
   logic                  vertex_last;

   modport source (
      output valid, req_type, shear_factor, vertex_x, vertex_y, vertex_last,
      input  ready
   );

   modport sink (
      input  valid, req_type, shear_factor, vertex_x, vertex_y, vertex_last,
      output ready
   );
endinterface

// ===== hw/rtl/afx_rsp_if.sv =====
// ----------------------------------------------------------------------------
// afx_rsp_if
// Response channel: valid/ready handshake with the transformed vertex.
// ----------------------------------------------------------------------------
interface afx_rsp_if;
   import afx_pkg::*;

   logic     valid;
   logic     ready;
   elem_type out_x;
   elem_type out_y;
   logic     out_last;

   modport source (
      output valid, out_x, out_y, out_last,
      input  ready
   );

   modport sink (
      input  valid, out_x, out_y, out_last,
      output ready
   );
endinterface

// ===== hw/rtl/afx_datapath.sv =====
// ----------------------------------------------------------------------------
// afx_datapath
// Single-pass arithmetic: applies one request to the matrix, or transforms
// one vertex by it.
// ----------------------------------------------------------------------------
module afx_datapath #(
   parameter int FRAC_BITS = afx_pkg::FRAC_BITS_DEF
) (
   input  afx_pkg::req_item_type item,
   input  afx_pkg::mat_type      matrix,
   output afx_pkg::mat_type      matrix_next,
   output afx_pkg::rsp_item_type result
);
   import afx_pkg::*;

   localparam elem_type UNIT = unit_value(FRAC_BITS);

   prod_type vx_p00, vx_p01, vx_p10, vx_p11;
   prod_type sh_p0, sh_p1;
   elem_type sh_src0, sh_src1, sh_base0, sh_base1;
   elem_type sh_new0, sh_new1;
   wide_type sum_x, sum_y;

   // Vertex products: a00*x + a01*y and a10*x + a11*y.
   assign vx_p00 = PROD_W'(matrix[0]) * PROD_W'(item.vertex_x);
   assign vx_p01 = PROD_W'(matrix[1]) * PROD_W'(item.vertex_y);
   assign vx_p10 = PROD_W'(matrix[2]) * PROD_W'(item.vertex_x);
   assign vx_p11 = PROD_W'(matrix[3]) * PROD_W'(item.vertex_y);

   // Full sums are floored by the fraction width, then clamped.
   assign sum_x = (WIDE_W'(vx_p00) + WIDE_W'(vx_p01)) >>> FRAC_BITS;
   assign sum_y = (WIDE_W'(vx_p10) + WIDE_W'(vx_p11)) >>> FRAC_BITS;

   // Shear in x reads row one and updates row zero; shear in y the reverse.
   always_comb begin
      if (item.req_type == REQ_SHEAR_X) begin
         sh_src0  = matrix[2];
         sh_src1  = matrix[3];
         sh_base0 = matrix[0];
         sh_base1 = matrix[1];
      end else begin
         sh_src0  = matrix[0];
         sh_src1  = matrix[1];
         sh_base0 = matrix[2];
         sh_base1 = matrix[3];
      end
   end

   assign sh_p0 = PROD_W'(item.shear_factor) * PROD_W'(sh_src0);
   assign sh_p1 = PROD_W'(item.shear_factor) * PROD_W'(sh_src1);

   assign sh_new0 = sat_elem((WIDE_W'(sh_p0) >>> FRAC_BITS) + WIDE_W'(sh_base0));
   assign sh_new1 = sat_elem((WIDE_W'(sh_p1) >>> FRAC_BITS) + WIDE_W'(sh_base1));

   always_comb begin
      matrix_next = matrix;
      case (req_code_type'(item.req_type))
         REQ_IDENTITY: begin
            matrix_next[0] = UNIT;
            matrix_next[1] = '0;
            matrix_next[2] = '0;
            matrix_next[3] = UNIT;
         end
         REQ_REFLECT_X: begin
            matrix_next[2] = neg_sat(matrix[2]);
            matrix_next[3] = neg_sat(matrix[3]);
         end
         REQ_REFLECT_Y: begin
            matrix_next[0] = neg_sat(matrix[0]);
            matrix_next[1] = neg_sat(matrix[1]);
         end
         REQ_REFLECT_ORG: begin
            matrix_next[0] = neg_sat(matrix[0]);
            matrix_next[1] = neg_sat(matrix[1]);
            matrix_next[2] = neg_sat(matrix[2]);
            matrix_next[3] = neg_sat(matrix[3]);
         end
         REQ_REFLECT_XY: begin
            matrix_next[0] = matrix[2];
            matrix_next[1] = matrix[3];
            matrix_next[2] = matrix[0];
            matrix_next[3] = matrix[1];
         end
         REQ_SHEAR_X: begin
            matrix_next[0] = sh_new0;
            matrix_next[1] = sh_new1;
         end
         REQ_SHEAR_Y: begin
            matrix_next[2] = sh_new0;
            matrix_next[3] = sh_new1;
         end
         REQ_VERTEX: begin
            matrix_next = matrix;
         end
         default: begin
            matrix_next = matrix;
         end
      endcase
   end

   assign result.out_x    = sat_elem(sum_x);
   assign result.out_y    = sat_elem(sum_y);
   assign result.out_last = item.vertex_last;

endmodule

// ===== hw/rtl/affine_2d_reflect_shear_transform_unit.sv =====
// ----------------------------------------------------------------------------
// affine_2d_reflect_shear_transform_unit
// Composite 2x2 fixed-point transform matrix with identity, reflect, swap and
// shear requests, and a vertex transform that returns one response.
// ----------------------------------------------------------------------------
// The unit takes one request per clock cycle while no vertex request is held
// back. A request is first captured in an input register. When it leaves
// that register, it either updates the matrix or, for a vertex request, loads
// its response into the output register. The response is therefore presented
// from the output register after its request has passed the input register.
// The throughput of one request per cycle comes from doing all the work in a
// single pass. That pass is either the four vertex multipliers with their
// sums, or the two shear multipliers with their adds, followed by the
// saturation logic. A vertex request waits in the input register only while
// the output register holds a response that has not been taken, and new
// requests wait with it. All other request types never wait. A matrix update
// is visible to the very next request. Only vertex requests give a response;
// all other request types are absorbed silently. All values are signed fixed
// point with FRAC_BITS fraction bits; products are floored and results are
// saturated to 32 bits. After reset the matrix is identity.
// ----------------------------------------------------------------------------
module affine_2d_reflect_shear_transform_unit #(
   parameter int FRAC_BITS = afx_pkg::FRAC_BITS_DEF
) (
   input logic         clock,
   input logic         reset,
   afx_req_if.sink     req_chan,
   afx_rsp_if.source   rsp_chan
);
   import afx_pkg::*;

   localparam elem_type UNIT = unit_value(FRAC_BITS);

   // Input register stage.
   logic         s1_valid_ff, s1_valid_in;
   req_item_type s1_item_ff, s1_item_in;

   // Output register stage.
   logic         out_valid_ff, out_valid_in;
   rsp_item_type out_item_ff, out_item_in;

   // Composite transform matrix.
   mat_type      matrix_ff, matrix_in;

   mat_type      dp_matrix_next;
   rsp_item_type dp_result;

   logic         req_accept;
   logic         s1_is_vertex;
   logic         s1_advance;

   // A held request may leave the input register whenever it does not need
   // the output register, or the output register is empty or being drained.
   assign s1_is_vertex = (s1_item_ff.req_type == REQ_VERTEX);
   assign s1_advance   = s1_valid_ff && (!s1_is_vertex || !out_valid_ff || rsp_chan.ready);

   assign req_chan.ready = !s1_valid_ff || s1_advance;
   assign req_accept     = req_chan.valid && req_chan.ready;

   always_comb begin
      s1_valid_in = req_accept || (s1_valid_ff && !s1_advance);
      s1_item_in  = s1_item_ff;
      if (req_accept) begin
         s1_item_in.req_type     = req_chan.req_type;
         s1_item_in.shear_factor = req_chan.shear_factor;
         s1_item_in.vertex_x     = req_chan.vertex_x;
         s1_item_in.vertex_y     = req_chan.vertex_y;
         s1_item_in.vertex_last  = req_chan.vertex_last;
      end
   end

   afx_datapath #(
      .FRAC_BITS (FRAC_BITS)
   ) u_afx_datapath (
      .item        (s1_item_ff),
      .matrix      (matrix_ff),
      .matrix_next (dp_matrix_next),
      .result      (dp_result)
   );

   // Requests update the matrix in order, exactly when they leave the input
   // register, so every vertex sees all earlier updates.
   assign matrix_in = s1_advance ? dp_matrix_next : matrix_ff;

   always_comb begin
      out_valid_in = out_valid_ff;
      out_item_in  = out_item_ff;
      if (s1_advance && s1_is_vertex) begin
         out_valid_in = 1'b1;
         out_item_in  = dp_result;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         matrix_ff[0] <= UNIT;
         matrix_ff[1] <= '0;
         matrix_ff[2] <= '0;
         matrix_ff[3] <= UNIT;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         matrix_ff    <= matrix_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_item_ff  <= s1_item_in;
      out_item_ff <= out_item_in;
   end

   assign rsp_chan.valid    = out_valid_ff;
   assign rsp_chan.out_x    = out_item_ff.out_x;
   assign rsp_chan.out_y    = out_item_ff.out_y;
   assign rsp_chan.out_last = out_item_ff.out_last;

endmodule

// ===== hw/rtl/afx_checker.sv =====
// ----------------------------------------------------------------------------
// afx_checker
// Port-level checks for the transform unit, bound to the top level.
// ----------------------------------------------------------------------------
module afx_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_ready,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic signed [afx_pkg::DATA_W-1:0] rsp_out_x,
   input logic signed [afx_pkg::DATA_W-1:0] rsp_out_y,
   input logic                           rsp_out_last
);
   import afx_pkg::*;

   // Reset empties the output register.
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // With nothing waiting at the output, a request is always taken.
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request stalled while output is empty");

   // A new response follows an accepted request that has passed the input register.
   a_rsp_has_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
      else $error("response without a matching request");

   // A stalled response holds its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_x)
         && $stable(rsp_out_y) && $stable(rsp_out_last))
      else $error("stalled response changed");

endmodule

bind affine_2d_reflect_shear_transform_unit afx_checker u_afx_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_chan.valid),
   .req_ready    (req_chan.ready),
   .rsp_valid    (rsp_chan.valid),
   .rsp_ready    (rsp_chan.ready),
   .rsp_out_x    (rsp_chan.out_x),
   .rsp_out_y    (rsp_chan.out_y),
   .rsp_out_last (rsp_chan.out_last)
);
